// File: hw/rtl/zmachine_memory_table_unit_macros.svh
// Assertion macros shared by the RTL of the memory table unit.
`ifndef ZMACHINE_MEMORY_TABLE_UNIT_MACROS_SVH
`define ZMACHINE_MEMORY_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ZM_ASSERT(label, clk, rst, prop, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ZM_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ZM_ASSERT(label, clk, rst, prop, msg)
`define ZM_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/zmmt_pkg.sv
`timescale 1ns / 1ps
package zmmt_pkg;
    localparam int unsigned MemoryBytesDefault = 65536;

    typedef enum logic [2:0] {
        FUNC_RAW_LOAD   = 3'd0,
        FUNC_LOADB      = 3'd1,
        FUNC_LOADW      = 3'd2,
        FUNC_STOREB     = 3'd3,
        FUNC_STOREW     = 3'd4,
        FUNC_COPY_TABLE = 3'd5,
        FUNC_SCAN_TABLE = 3'd6,
        FUNC_UNUSED     = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_READ  = 2'd1,
        ERR_WRITE = 2'd2
    } err_t;

    localparam logic [0:0] CFG_STATIC_START = 1'b0;
    localparam logic [0:0] CFG_STATIC_END   = 1'b1;

    localparam logic [7:0] FORM_DEFAULT = 8'h82;
    localparam logic [15:0] ADDR_FLAGS1 = 16'h0001;
    localparam logic [15:0] ADDR_FLAGS2_HI = 16'h0010;
    localparam logic [15:0] ADDR_FLAGS2_LO = 16'h0011;
    localparam logic [15:0] ADDR_DYN_FIRST = 16'h0040;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [15:0] arg_c;
        logic [7:0]  scan_form;
        logic        form_given;
    } zm_in_t;

    typedef struct packed {
        logic [15:0] value;
        logic        branch;
        logic [1:0]  error;
    } zm_out_t;
endpackage

// File: hw/rtl/zmachine_memory_table_unit.sv
`timescale 1ns / 1ps
// Byte-wide story memory with one synchronous single-port RAM. Every byte access presents
// the address first; the registered byte is taken in the following cycle and, for a write,
// checked and written back then. copy_table copies or zero-fills byte by byte and
// scan_table reads its byte or word entries one at a time; an error ends the walk early.
// The single RAM port serialises every access. A new input transfer is taken only once
// the previous result has been taken. Configuration writes are accepted in any cycle and
// should be made only while no operation is in flight.
`include "zmachine_memory_table_unit_macros.svh"
module zmachine_memory_table_unit
    import zmmt_pkg::*;
#(
    parameter int unsigned MEMORY_BYTES = MemoryBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  zm_in_t      s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output zm_out_t     m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int unsigned AW = $clog2(MEMORY_BYTES);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ISSUE = 7'b0000010,
        ST_DATA  = 7'b0000100,
        ST_NEXT  = 7'b0001000,
        ST_WADDR = 7'b0010000,
        ST_WDATA = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] sstart_reg, sstart_next, send_reg, send_next;
    zm_in_t      op_reg, op_next;
    logic [15:0] raddr_reg, raddr_next;   // read pointer / element address
    logic [15:0] waddr_reg, waddr_next;
    logic [15:0] cnt_reg, cnt_next;       // elements still to do
    logic [15:0] word_reg, word_next;     // assembled word or byte to write
    logic        half_reg, half_next;     // second byte of a word
    logic        rd_mode_reg, rd_mode_next;
    logic        bwd_reg, bwd_next;
    logic        zero_reg, zero_next;
    logic [7:0]  form_reg, form_next;
    zm_out_t     res_reg, res_next;
    logic        mv_reg, mv_next;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    zmmt_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_ram (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata (ram_wdata), .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !mv_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = mv_reg;
    assign m_data    = res_reg;

    // Guard check on a write of byte v over old contents at address a.
    function automatic logic [1:0] wcheck(input logic [15:0] a, input logic [7:0] v,
                                          input logic [7:0] old, input logic [15:0] ss);
        logic [1:0] r;
        r = 2'd0;                       // 0 write, 1 skip, 2 refuse
        if (a == ADDR_FLAGS1) begin
            if (v != old && (old ^ v) != 8'h08) r = 2'd2;
        end else if (a == ADDR_FLAGS2_HI && old == v) begin
            r = 2'd1;
        end else if (a == ADDR_FLAGS2_LO) begin
            if ((old ^ v) >= 8'h08) r = 2'd2;
        end else if (a < ADDR_DYN_FIRST || a >= ss) begin
            r = 2'd2;
        end
        return r;
    endfunction

    logic [15:0] cur_rd_a;
    logic [1:0]  wc;
    logic [15:0] st_ab, st_a2b;

    always_comb begin
        state_next   = state_reg;
        sstart_next  = sstart_reg;
        send_next    = send_reg;
        op_next      = op_reg;
        raddr_next   = raddr_reg;
        waddr_next   = waddr_reg;
        cnt_next     = cnt_reg;
        word_next    = word_reg;
        half_next    = half_reg;
        rd_mode_next = rd_mode_reg;
        bwd_next     = bwd_reg;
        zero_next    = zero_reg;
        form_next    = form_reg;
        res_next     = res_reg;
        mv_next      = mv_reg;
        ram_we       = 1'b0;
        ram_addr     = raddr_reg[AW-1:0];
        ram_wdata    = word_reg[7:0];
        st_ab        = s_data.arg_a + s_data.arg_b;
        st_a2b       = s_data.arg_a + {s_data.arg_b[14:0], 1'b0};
        cur_rd_a     = raddr_reg + {15'd0, half_reg};
        wc           = wcheck(waddr_reg, word_reg[7:0], ram_rdata, sstart_reg);

        if (mv_reg && m_ready) mv_next = 1'b0;
        if (cfg_valid) begin
            if (cfg_index == CFG_STATIC_START) sstart_next = cfg_data;
            else send_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next   = s_data;
                    half_next = 1'b0;
                    bwd_next  = 1'b0;
                    zero_next = 1'b0;
                    res_next  = '0;
                    form_next = s_data.form_given ? s_data.scan_form : FORM_DEFAULT;
                    state_next = ST_ISSUE;
                    case (func_t'(s_data.func))
                        FUNC_RAW_LOAD: begin
                            raddr_next = s_data.arg_a; cnt_next = 16'd1; rd_mode_next = 1'b0;
                        end
                        FUNC_LOADB: begin
                            raddr_next = st_ab; cnt_next = 16'd1; rd_mode_next = 1'b1;
                        end
                        FUNC_LOADW: begin
                            raddr_next = st_a2b; cnt_next = 16'd1; rd_mode_next = 1'b1;
                        end
                        FUNC_STOREB: begin
                            waddr_next = st_ab; word_next = s_data.arg_c; cnt_next = 16'd1;
                            state_next = ST_WADDR;
                        end
                        FUNC_STOREW: begin
                            waddr_next = st_a2b; word_next = {8'd0, s_data.arg_c[15:8]};
                            cnt_next = 16'd2; state_next = ST_WADDR;
                        end
                        FUNC_COPY_TABLE: begin
                            rd_mode_next = 1'b1;
                            if (s_data.arg_b == 16'd0) begin
                                zero_next = 1'b1; waddr_next = s_data.arg_a;
                                cnt_next = s_data.arg_c; word_next = '0;
                                state_next = ST_WADDR;
                            end else if (s_data.arg_a > s_data.arg_b || s_data.arg_c[15]) begin
                                raddr_next = s_data.arg_a; waddr_next = s_data.arg_b;
                                cnt_next = s_data.arg_c[15] ? (16'd0 - s_data.arg_c)
                                                            : s_data.arg_c;
                            end else begin
                                bwd_next = 1'b1;
                                raddr_next = s_data.arg_a + s_data.arg_c - 16'd1;
                                waddr_next = s_data.arg_b + s_data.arg_c - 16'd1;
                                cnt_next = s_data.arg_c;
                            end
                            if (!(s_data.arg_b == 16'd0) && s_data.arg_c == 16'd0)
                                state_next = ST_DONE;
                            if (s_data.arg_b == 16'd0 && s_data.arg_c == 16'd0)
                                state_next = ST_DONE;
                        end
                        FUNC_SCAN_TABLE: begin
                            raddr_next = s_data.arg_b; cnt_next = s_data.arg_c;
                            rd_mode_next = 1'b1;
                            state_next = (s_data.arg_c == 16'd0) ? ST_DONE : ST_ISSUE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_ISSUE: begin
                // Bounds are checked before the byte is fetched.
                ram_addr = cur_rd_a[AW-1:0];
                if (rd_mode_reg && ((op_reg.func == FUNC_LOADW ||
                        (op_reg.func == FUNC_SCAN_TABLE && form_reg[7]))
                        ? ({1'b0, raddr_reg} + 17'd1 >= {1'b0, send_reg})
                        : (cur_rd_a >= send_reg))) begin
                    res_next.error = ERR_READ;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                word_next = {word_reg[7:0], ram_rdata};
                if ((op_reg.func == FUNC_LOADW ||
                        (op_reg.func == FUNC_SCAN_TABLE && form_reg[7])) && !half_reg) begin
                    half_next = 1'b1;
                    state_next = ST_ISSUE;
                end else begin
                    half_next = 1'b0;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (op_reg.func == FUNC_COPY_TABLE) begin
                    word_next = {8'd0, word_reg[7:0]};
                    state_next = ST_WADDR;
                end else if (op_reg.func == FUNC_SCAN_TABLE) begin
                    if ((form_reg[7] ? word_reg : {8'd0, word_reg[7:0]}) == op_reg.arg_a) begin
                        res_next.value = raddr_reg; res_next.branch = 1'b1;
                        state_next = ST_DONE;
                    end else if (cnt_reg == 16'd1) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next = cnt_reg - 16'd1;
                        raddr_next = raddr_reg + {9'd0, form_reg[6:0]};
                        state_next = ST_ISSUE;
                    end
                end else begin
                    res_next.value = (op_reg.func == FUNC_LOADW) ? word_reg
                                                                 : {8'd0, word_reg[7:0]};
                    state_next = ST_DONE;
                end
            end
            ST_WADDR: begin
                ram_addr = waddr_reg[AW-1:0];
                state_next = ST_WDATA;
            end
            ST_WDATA: begin
                // Old byte in hand: apply header and bounds rules, then write back.
                ram_addr = waddr_reg[AW-1:0];
                if (wc == 2'd2) begin
                    res_next.error = ERR_WRITE;
                    state_next = ST_DONE;
                end else begin
                    ram_we = (wc == 2'd0);
                    if (cnt_reg == 16'd1) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next = cnt_reg - 16'd1;
                        if (op_reg.func == FUNC_STOREW) begin
                            waddr_next = waddr_reg + 16'd1;
                            word_next = {8'd0, op_reg.arg_c[7:0]};
                            state_next = ST_WADDR;
                        end else if (zero_reg) begin
                            waddr_next = waddr_reg + 16'd1;
                            state_next = ST_WADDR;
                        end else begin
                            raddr_next = bwd_reg ? raddr_reg - 16'd1 : raddr_reg + 16'd1;
                            waddr_next = bwd_reg ? waddr_reg - 16'd1 : waddr_reg + 16'd1;
                            state_next = ST_ISSUE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    if (res_next.error != ERR_NONE) begin
                        res_next.value = '0; res_next.branch = 1'b0;
                    end
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sstart_reg <= 16'd64;
            send_reg   <= 16'hFFFF;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sstart_reg <= sstart_next;
            send_reg   <= send_next;
            mv_reg     <= mv_next;
        end
        op_reg      <= op_next;
        raddr_reg   <= raddr_next;
        waddr_reg   <= waddr_next;
        cnt_reg     <= cnt_next;
        word_reg    <= word_next;
        half_reg    <= half_next;
        rd_mode_reg <= rd_mode_next;
        bwd_reg     <= bwd_next;
        zero_reg    <= zero_next;
        form_reg    <= form_next;
        res_reg     <= res_next;
    end

    `ZM_ASSERT(a_accept_idle, aclk, !aresetn, (s_valid && s_ready) |=> (state_reg != ST_IDLE), "transfer taken without starting an operation")
    `ZM_ASSERT(a_no_write_read, aclk, !aresetn, ram_we |-> (state_reg == ST_WDATA), "RAM written outside the write-back step")
    `ZM_ASSERT(a_err_clean, aclk, !aresetn, (m_valid && m_data.error != ERR_NONE) |-> (m_data.value == 16'd0 && !m_data.branch), "error result carries data")
    `ZM_ASSERT(a_done_valid, aclk, !aresetn, (state_reg == ST_DONE && !mv_reg) |=> mv_reg, "finished operation did not present a result")
endmodule

// File: hw/rtl/zmmt_ram.sv
`timescale 1ns / 1ps
module zmmt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import zmmt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    zm_in_t      s_data;
    logic        m_valid;
    logic        m_ready;
    zm_out_t     m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    typedef struct {
        logic [15:0] addr;
        logic [7:0]  data;
        bit          was_known;
    } undo_t;

    // Shadow of the story memory and of which bytes have been written so far.
    logic [7:0]  mem_img [65536];
    bit          known [65536];
    undo_t       undo_log [$];
    bit          touched_unknown;
    logic [15:0] ro_start;
    logic [15:0] read_end;

    zm_out_t     pending_results [$];
    int          mismatches;
    bit          ready_steady;
    int          ready_hold;

    zmachine_memory_table_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic err_t get_byte(input logic [15:0] addr, output logic [7:0] v);
        if (addr >= read_end) begin
            return ERR_READ;
        end
        if (!known[addr]) begin
            touched_unknown = 1'b1;
        end
        v = mem_img[addr];
        return ERR_NONE;
    endfunction

    function automatic err_t get_word(input logic [15:0] addr, output logic [15:0] v);
        logic [7:0] hi;
        logic [7:0] lo;
        if ({1'b0, addr} + 17'd1 >= {1'b0, read_end}) begin
            return ERR_READ;
        end
        void'(get_byte(addr, hi));
        void'(get_byte(addr + 16'd1, lo));
        v = {hi, lo};
        return ERR_NONE;
    endfunction

    function automatic err_t put_byte(input logic [15:0] addr, input logic [7:0] v);
        logic [7:0] old;
        if ((addr == ADDR_FLAGS1 || addr == ADDR_FLAGS2_HI || addr == ADDR_FLAGS2_LO)
                && !known[addr]) begin
            touched_unknown = 1'b1;
        end
        old = mem_img[addr];
        if (addr == ADDR_FLAGS1) begin
            if (v != old && (old ^ v) != 8'h08) begin
                return ERR_WRITE;
            end
        end else if (addr == ADDR_FLAGS2_HI && old == v) begin
            return ERR_NONE;
        end else if (addr == ADDR_FLAGS2_LO) begin
            if ((old ^ v) >= 8'h08) begin
                return ERR_WRITE;
            end
        end else if (addr < ADDR_DYN_FIRST || addr >= ro_start) begin
            return ERR_WRITE;
        end
        undo_log.push_back('{addr, old, known[addr]});
        mem_img[addr] = v;
        known[addr] = 1'b1;
        return ERR_NONE;
    endfunction

    function automatic err_t copy_bytes(input logic [15:0] src, input logic [15:0] dst,
                                        input logic [15:0] size);
        logic [7:0]  b;
        logic [15:0] n;
        err_t        e;
        if (dst == 16'd0) begin
            for (int i = 0; i < size; i++) begin
                e = put_byte(src + 16'(i), 8'd0);
                if (e != ERR_NONE) return e;
            end
        end else if (src > dst || size[15]) begin
            n = size[15] ? -size : size;
            for (int i = 0; i < ((size == 16'h8000) ? 32768 : int'(n)); i++) begin
                e = get_byte(src + 16'(i), b);
                if (e != ERR_NONE) return e;
                e = put_byte(dst + 16'(i), b);
                if (e != ERR_NONE) return e;
            end
        end else begin
            for (int i = 0; i < size; i++) begin
                e = get_byte(src + size - 16'(i) - 16'd1, b);
                if (e != ERR_NONE) return e;
                e = put_byte(dst + size - 16'(i) - 16'd1, b);
                if (e != ERR_NONE) return e;
            end
        end
        return ERR_NONE;
    endfunction

    function automatic zm_out_t compute_access(input zm_in_t it);
        zm_out_t     r;
        err_t        e;
        logic [7:0]  form;
        logic [7:0]  b;
        logic [15:0] w;
        logic [15:0] addr;
        r = '0;
        e = ERR_NONE;
        form = it.form_given ? it.scan_form : FORM_DEFAULT;
        case (func_t'(it.func))
            FUNC_RAW_LOAD: begin
                if (!known[it.arg_a]) touched_unknown = 1'b1;
                r.value = {8'd0, mem_img[it.arg_a]};
            end
            FUNC_LOADB: begin
                e = get_byte(it.arg_a + it.arg_b, b);
                r.value = {8'd0, b};
            end
            FUNC_LOADW: begin
                e = get_word(it.arg_a + 16'd2 * it.arg_b, w);
                r.value = w;
            end
            FUNC_STOREB: e = put_byte(it.arg_a + it.arg_b, it.arg_c[7:0]);
            FUNC_STOREW: begin
                addr = it.arg_a + 16'd2 * it.arg_b;
                e = put_byte(addr, it.arg_c[15:8]);
                if (e == ERR_NONE) e = put_byte(addr + 16'd1, it.arg_c[7:0]);
            end
            FUNC_COPY_TABLE: e = copy_bytes(it.arg_a, it.arg_b, it.arg_c);
            FUNC_SCAN_TABLE: begin
                addr = it.arg_b;
                for (int i = 0; i < it.arg_c; i++) begin
                    if (form[7]) begin
                        e = get_word(addr, w);
                    end else begin
                        e = get_byte(addr, b);
                        w = {8'd0, b};
                    end
                    if (e != ERR_NONE) break;
                    if (w == it.arg_a) begin
                        r.value = addr;
                        r.branch = 1'b1;
                        break;
                    end
                    addr = addr + {9'd0, form[6:0]};
                end
            end
            default: ;
        endcase
        if (e != ERR_NONE) begin
            r.value = '0;
            r.branch = 1'b0;
        end
        r.error = e;
        return r;
    endfunction

    // Predicts an item and queues its result, unless it would read a byte that was never
    // written, in which case the shadow is rolled back and the item is dropped.
    function automatic bit admit_item(input zm_in_t it);
        zm_out_t r;
        undo_t   u;
        touched_unknown = 1'b0;
        undo_log.delete();
        r = compute_access(it);
        if (touched_unknown) begin
            while (undo_log.size() > 0) begin
                u = undo_log.pop_back();
                mem_img[u.addr] = u.data;
                known[u.addr] = u.was_known;
            end
            return 1'b0;
        end
        pending_results.push_back(r);
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input zm_in_t it, input bit with_gaps);
        int g;
        if (!admit_item(it)) return;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        g = with_gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_STATIC_START) ro_start = val;
        else read_end = val;
        @(posedge aclk);
    endtask

    task automatic set_limits(input logic [15:0] first_ro, input logic [15:0] end_rd);
        write_reg(CFG_STATIC_START, first_ro);
        write_reg(CFG_STATIC_END, end_rd);
    endtask

    function automatic zm_in_t make_item(input func_t f, input logic [15:0] a,
                                         input logic [15:0] b, input logic [15:0] c,
                                         input logic [7:0] form, input bit given);
        zm_in_t it;
        it.func = f;
        it.arg_a = a;
        it.arg_b = b;
        it.arg_c = c;
        it.scan_form = form;
        it.form_given = given;
        return it;
    endfunction

    function automatic logic [15:0] pick_addr();
        if ($urandom_range(0, 19) == 0) return 16'($urandom);
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(16'hFF00, 16'hFFFF));
        return 16'($urandom_range(16'h0040, 16'h03FF));
    endfunction

    function automatic zm_in_t random_item();
        logic [15:0] t;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [7:0]  form;
        logic [15:0] probe;
        bit          given;
        func_t       f;
        f = func_t'($urandom_range(0, 7));
        t = pick_addr();
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        form = 8'($urandom);
        given = 1'($urandom);
        case (f)
            FUNC_RAW_LOAD:  a = t;
            FUNC_LOADB, FUNC_STOREB: b = t - a;
            FUNC_LOADW, FUNC_STOREW: a = t - 16'd2 * b;
            FUNC_COPY_TABLE: begin
                a = t;
                case ($urandom_range(0, 3))
                    0: b = 16'd0;
                    1: b = t + 16'($urandom_range(0, 8)) - 16'd4;
                    default: b = pick_addr();
                endcase
                c = 16'($urandom_range(0, 40));
                if ($urandom_range(0, 3) == 0) c = -c;
            end
            FUNC_SCAN_TABLE: begin
                b = t;
                c = 16'($urandom_range(0, 24));
                if ($urandom_range(0, 3) == 0) form[6:0] = 7'($urandom_range(0, 4));
                probe = t + 16'($urandom_range(0, 12)) * {9'd0, (given ? form[6:0] : 7'd2)};
                if ($urandom_range(0, 2) != 0)
                    a = ((given ? form[7] : 1'b1) && probe != 16'hFFFF)
                        ? {mem_img[probe], mem_img[probe + 16'd1]} : {8'd0, mem_img[probe]};
            end
            default: ;
        endcase
        return make_item(f, a, b, c, form, given);
    endfunction

    task automatic run_random(input int count);
        zm_in_t it;
        for (int n = 0; n < count; n++) begin
            ready_steady = ($urandom_range(0, 99) < 10) ? ~ready_steady : ready_steady;
            for (int k = 0; k < 40; k++) begin
                it = random_item();
                if (admit_probe(it)) break;
                if (k == 39) it = make_item(FUNC_UNUSED, 16'($urandom), 16'($urandom),
                                            16'($urandom), 8'($urandom), 1'($urandom));
            end
            send_item(it, !ready_steady);
        end
    endtask

    // Checks whether an item is safe without keeping its effects.
    function automatic bit admit_probe(input zm_in_t it);
        undo_t   u;
        zm_out_t r;
        touched_unknown = 1'b0;
        undo_log.delete();
        r = compute_access(it);
        while (undo_log.size() > 0) begin
            u = undo_log.pop_back();
            mem_img[u.addr] = u.data;
            known[u.addr] = u.was_known;
        end
        return !touched_unknown;
    endfunction

    task automatic test_fill();
        set_limits(16'hFFFF, 16'hFFFF);
        send_item(make_item(FUNC_COPY_TABLE, 16'h0040, 16'd0, 16'h03C0, 8'h00, 1'b0), 1'b0);
        send_item(make_item(FUNC_COPY_TABLE, 16'hFF00, 16'd0, 16'h00FF, 8'h00, 1'b0), 1'b0);
        for (int i = 0; i < 64; i++)
            send_item(make_item(FUNC_STOREW, 16'h0040, 16'(i * 7), 16'($urandom),
                                8'h00, 1'b0), 1'b1);
    endtask

    task automatic test_directed();
        send_item(make_item(FUNC_STOREB, 16'hFFFF, 16'h0041, 16'hFFAB, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_LOADB, 16'hFFFF, 16'h0041, 16'h0000, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_RAW_LOAD, 16'h0040, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1), 1'b1);
        send_item(make_item(FUNC_STOREW, 16'hFF00, 16'h00FE, 16'hFFFF, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_LOADW, 16'hFF00, 16'h00FE, 16'h0000, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_STOREW, 16'hFFFE, 16'h0000, 16'h1234, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_LOADW, 16'hFFFE, 16'h0000, 16'h0000, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_STOREB, 16'h0000, 16'h0000, 16'h0055, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_STOREB, 16'h0002, 16'h003D, 16'h0055, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_STOREB, 16'hFFFF, 16'h0000, 16'h0001, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_COPY_TABLE, 16'h0050, 16'h0058, 16'h0010, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_COPY_TABLE, 16'h0058, 16'h0050, 16'h0010, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_COPY_TABLE, 16'h0050, 16'h0058, 16'hFFF0, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_COPY_TABLE, 16'h0100, 16'h0000, 16'h0000, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_COPY_TABLE, 16'h0040, 16'h0100, 16'h8000, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_SCAN_TABLE, {8'd0, mem_img[16'h0060]}, 16'h0040, 16'h0030,
                            8'h01, 1'b1), 1'b1);
        send_item(make_item(FUNC_SCAN_TABLE, {mem_img[16'h0060], mem_img[16'h0061]},
                            16'h0040, 16'h0020, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_SCAN_TABLE, 16'hFFFF, 16'h0040, 16'h0008, 8'h80, 1'b1), 1'b1);
        send_item(make_item(FUNC_SCAN_TABLE, 16'h0000, 16'h0040, 16'h0000, 8'h7F, 1'b1), 1'b1);
        send_item(make_item(FUNC_SCAN_TABLE, 16'hBEEF, 16'hFFF0, 16'h0040, 8'hFF, 1'b1), 1'b1);
        send_item(make_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1), 1'b1);
        set_limits(16'h0000, 16'h0000);
        send_item(make_item(FUNC_LOADB, 16'h0040, 16'h0000, 16'h0000, 8'h00, 1'b0), 1'b1);
        send_item(make_item(FUNC_STOREB, 16'h0040, 16'h0000, 16'h00AA, 8'h00, 1'b0), 1'b1);
        set_limits(16'hFFFF, 16'h0001);
        send_item(make_item(FUNC_LOADW, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0), 1'b1);
    endtask

    task automatic test_random_limits();
        set_limits(16'hFFFF, 16'hFFFF);
        run_random(500);
        set_limits(16'h0200, 16'h0300);
        run_random(350);
        set_limits(16'h0041, 16'h8000);
        run_random(300);
        set_limits(16'h0000, 16'h0000);
        run_random(150);
        set_limits(16'h0400, 16'h0041);
        run_random(200);
        set_limits(16'hFFFF, 16'hFFFE);
        run_random(300);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (ready_steady) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 99) == 0) begin
            ready_hold = $urandom_range(10, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        zm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result transfer", m_data.value, 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.value !== want.value) report("value", m_data.value, want.value);
                if (m_data.branch !== want.branch)
                    report("branch", 16'(m_data.branch), 16'(want.branch));
                if (m_data.error !== want.error)
                    report("error", 16'(m_data.error), 16'(want.error));
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_STATIC_START;
        cfg_data <= '0;
        mismatches = 0;
        ready_steady = 1'b0;
        ready_hold = 0;
        ro_start = 16'd64;
        read_end = 16'hFFFF;
        for (int i = 0; i < 65536; i++) begin
            mem_img[i] = 8'd0;
            known[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill();
        test_directed();
        test_random_limits();
        settle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
